// File: rtl/tsa_pkg.sv
// Shared types and constants of the tangent space accumulator.
package tsa_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int VADDR_W      = $clog2(MAX_VERTICES);

  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_FACE = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic [9:0]         vertex_index;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic signed [23:0] tex_u;
    logic signed [23:0] tex_v;
    logic [9:0]         corner_a;
    logic [9:0]         corner_b;
    logic [9:0]         corner_c;
  } cmd_t;

  typedef struct packed {
    logic signed [23:0] tangent_x;
    logic signed [23:0] tangent_y;
    logic signed [23:0] tangent_z;
    logic               touched;
    logic               zero_length;
    logic               degenerate_seen;
  } rsp_t;

endpackage

// File: rtl/tangent_space_accumulator.sv
// Top level of the tangent space accumulator: vertex store, sequencer and shared datapath.
//
// The block keeps positions, texture coordinates and tangent sums for up to
// MAX_VERTICES vertices and handles one command beat at a time; cmd_stall is
// high while a command is being worked on. After reset a clearing pass over
// all MAX_VERTICES entries zeroes every tangent sum and touched flag, and no
// command is taken until it ends. A face takes the beat, fetches the corners,
// forms the differences, uses the shared 31x31 multiplier for the determinant
// and three numerators, runs three divides in the radix-2 restoring divider,
// and does the three read-modify-writes of the sum store; a face with a zero
// determinant ends once the determinant is known. A read fetches the sum,
// makes any one-bit normalizing shifts, takes a bit-by-bit square root and
// runs three divides; a zero sum skips straight to the result. The result
// sits in an output register, so the next command is taken while it waits.
module tangent_space_accumulator (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  tsa_pkg::cmd_t cmd,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output tsa_pkg::rsp_t rsp
);
  import tsa_pkg::*;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_LOAD, ST_FRD, ST_DIFF, ST_FMUL, ST_FACC,
    ST_DLOAD, ST_DSTEP, ST_DEND, ST_RMW_RD, ST_RMW_WR, ST_RRD, ST_RCAP,
    ST_NORM, ST_SQM, ST_SQA, ST_ROOT, ST_OUT
  } state_t;

  // Vertex store memories.
  logic [2:0][23:0] pos_mem [MAX_VERTICES];
  logic [1:0][23:0] tex_mem [MAX_VERTICES];
  logic [2:0][47:0] sum_mem [MAX_VERTICES];
  logic             tch_mem [MAX_VERTICES];
  logic [2:0][23:0] pos_rd;
  logic [1:0][23:0] tex_rd;
  logic [2:0][47:0] sum_rd;
  logic             tch_rd;

  state_t               state;
  logic [2:0]           cnt;
  logic [VADDR_W-1:0]   clr;
  cmd_t                 cur;
  logic                 deg;

  // Face datapath registers.
  logic [2:0][23:0]     pv [3];
  logic [1:0][23:0]     tv [3];
  logic signed [24:0]   dv1, dv2, du1, du2;
  logic signed [24:0]   dp0 [3];
  logic signed [24:0]   dp1 [3];
  logic signed [61:0]   mul_p;
  logic signed [51:0]   acc;
  logic signed [51:0]   det;
  logic signed [51:0]   num [3];
  logic signed [47:0]   tq [3];

  // Divider registers.
  logic [51:0]          rem;
  logic [39:0]          dq;
  logic [51:0]          dvs;
  logic [5:0]           dstep;
  logic                 dsat;

  // Read datapath registers.
  logic [47:0]          mag [3];
  logic                 mneg [3];
  logic [47:0]          mx;
  logic                 tch;
  logic                 zero;
  logic                 degen;
  logic [61:0]          ss;
  logic [61:0]          sx;
  logic [61:0]          sr;
  logic [61:0]          sbit;
  logic [30:0]          len;
  logic signed [23:0]   res [3];

  // Combinational signals.
  logic [VADDR_W-1:0]   mem_addr;
  logic                 vi_ok;
  logic                 rd_mode;
  logic                 pos_we, sum_we;
  logic [2:0][47:0]     sum_wd;
  logic signed [30:0]   mul_a, mul_b;
  logic signed [51:0]   mac;
  logic [61:0]          ss_sum;
  logic [61:0]          root_try;
  logic [73:0]          dvd;
  logic [51:0]          dvs_in;
  logic [52:0]          div_sh;
  logic [52:0]          div_diff;
  logic                 div_ge;
  logic [39:0]          qv;
  logic [47:0]          cap_m [3];
  logic [47:0]          cap_max;

  function automatic logic [51:0] abs52(input logic signed [51:0] v);
    return v[51] ? 52'(-v) : 52'(v);
  endfunction

  function automatic logic [47:0] abs48(input logic signed [47:0] v);
    return v[47] ? 48'(-v) : 48'(v);
  endfunction

  function automatic logic [47:0] sat48(input logic signed [47:0] a,
                                        input logic signed [47:0] b);
    logic signed [48:0] s;
    s = {a[47], a} + {b[47], b};
    if (s[48] != s[47]) begin
      return s[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    end
    return s[47:0];
  endfunction

  function automatic logic [VADDR_W-1:0] corner_sel(input cmd_t c, input logic [2:0] k);
    case (k)
      3'd0:    return c.corner_a[VADDR_W-1:0];
      3'd1:    return c.corner_b[VADDR_W-1:0];
      default: return c.corner_c[VADDR_W-1:0];
    endcase
  endfunction

  function automatic logic idx_ok(input logic [9:0] idx);
    return {22'd0, idx} < 32'(MAX_VERTICES);
  endfunction

  assign cmd_stall = (state != ST_IDLE);
  assign vi_ok     = idx_ok(cur.vertex_index);
  assign rd_mode   = (cur.action == ACT_READ);

  always_comb begin
    case (state)
      ST_CLEAR:             mem_addr = clr;
      ST_FRD:               mem_addr = corner_sel(cur, cnt);
      ST_RMW_RD, ST_RMW_WR: mem_addr = corner_sel(cur, cnt);
      default:              mem_addr = cur.vertex_index[VADDR_W-1:0];
    endcase
  end

  // A load writes the vertex and clears its sum; the clearing pass and the
  // face update also write the sum store.
  assign pos_we = (state == ST_LOAD) && vi_ok;
  assign sum_we = (state == ST_CLEAR) || pos_we || (state == ST_RMW_WR);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum_wd[k] = (state == ST_RMW_WR) ? sat48(sum_rd[k], tq[k]) : 48'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[mem_addr] <= {cur.pos_z, cur.pos_y, cur.pos_x};
      tex_mem[mem_addr] <= {cur.tex_v, cur.tex_u};
    end
    pos_rd <= pos_mem[mem_addr];
    tex_rd <= tex_mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_mem[mem_addr] <= sum_wd;
      tch_mem[mem_addr] <= (state == ST_RMW_WR);
    end
    sum_rd <= sum_mem[mem_addr];
    tch_rd <= tch_mem[mem_addr];
  end

  // Shared multiplier operands: face products first, squares on a read.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_FMUL: begin
        case (cnt)
          3'd0:    begin mul_a = 31'(dv1);    mul_b = 31'(du2); end
          3'd1:    begin mul_a = 31'(dv2);    mul_b = 31'(du1); end
          3'd2:    begin mul_a = 31'(dp0[0]); mul_b = 31'(dv2); end
          3'd3:    begin mul_a = 31'(dp1[0]); mul_b = 31'(dv1); end
          3'd4:    begin mul_a = 31'(dp0[1]); mul_b = 31'(dv2); end
          3'd5:    begin mul_a = 31'(dp1[1]); mul_b = 31'(dv1); end
          3'd6:    begin mul_a = 31'(dp0[2]); mul_b = 31'(dv2); end
          default: begin mul_a = 31'(dp1[2]); mul_b = 31'(dv1); end
        endcase
      end
      ST_SQM: begin
        mul_a = {1'b0, mag[cnt[1:0]][29:0]};
        mul_b = {1'b0, mag[cnt[1:0]][29:0]};
      end
      default: begin
      end
    endcase
  end

  assign mac      = (cnt == 3'd1) ? acc - 52'(mul_p) : acc + 52'(mul_p);
  assign ss_sum   = ((cnt == 3'd0) ? 62'd0 : ss) + $unsigned(mul_p);
  assign root_try = sr + sbit;

  // Divider input: |num| * 2^22 over |det| for a face, rounded m * 2^22 over
  // the length on a read. The top bits form the starting remainder.
  always_comb begin
    if (rd_mode) begin
      dvd    = {22'd0, mag[cnt[1:0]][29:0], 22'd0} + {44'd0, len[30:1]};
      dvs_in = {21'd0, len};
    end else begin
      dvd    = {abs52(num[cnt[1:0]]), 22'd0};
      dvs_in = abs52(det);
    end
  end

  assign div_sh   = {rem, dq[39]};
  assign div_ge   = (div_sh >= {1'b0, dvs});
  assign div_diff = div_sh - {1'b0, dvs};
  assign qv       = (dsat && !rd_mode) ? {40{1'b1}} : dq;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cap_m[k] = vi_ok ? abs48(sum_rd[k]) : 48'd0;
    end
    cap_max = cap_m[0];
    if (cap_m[1] > cap_max) cap_max = cap_m[1];
    if (cap_m[2] > cap_max) cap_max = cap_m[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr       <= '0;
      cnt       <= '0;
      deg       <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      mul_p <= 62'(mul_a) * 62'(mul_b);
      // A new result loaded in ST_OUT keeps the valid flag up.
      if (rsp_valid && !rsp_stall && state != ST_OUT) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == VADDR_W'(MAX_VERTICES - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          cnt <= '0;
          if (cmd_valid) begin
            cur <= cmd;
            case (cmd.action)
              ACT_LOAD: state <= ST_LOAD;
              ACT_FACE: begin
                if (idx_ok(cmd.corner_a) && idx_ok(cmd.corner_b) &&
                    idx_ok(cmd.corner_c)) begin
                  state <= ST_FRD;
                end
              end
              ACT_READ: state <= ST_RRD;
              default: begin
              end
            endcase
          end
        end
        ST_LOAD: state <= ST_IDLE;
        ST_FRD: begin
          case (cnt)
            3'd1: begin pv[0] <= pos_rd; tv[0] <= tex_rd; end
            3'd2: begin pv[1] <= pos_rd; tv[1] <= tex_rd; end
            3'd3: begin pv[2] <= pos_rd; tv[2] <= tex_rd; end
            default: begin
            end
          endcase
          if (cnt == 3'd3) begin
            cnt   <= '0;
            state <= ST_DIFF;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_DIFF: begin
          dv1 <= 25'($signed(tv[0][1])) - 25'($signed(tv[2][1]));
          dv2 <= 25'($signed(tv[2][1])) - 25'($signed(tv[1][1]));
          du1 <= 25'($signed(tv[2][0])) - 25'($signed(tv[0][0]));
          du2 <= 25'($signed(tv[1][0])) - 25'($signed(tv[2][0]));
          for (int k = 0; k < 3; k++) begin
            dp0[k] <= 25'($signed(pv[0][k])) - 25'($signed(pv[2][k]));
            dp1[k] <= 25'($signed(pv[1][k])) - 25'($signed(pv[2][k]));
          end
          state <= ST_FMUL;
        end
        ST_FMUL: state <= ST_FACC;
        ST_FACC: begin
          if (!cnt[0]) begin
            acc   <= 52'(mul_p);
            cnt   <= cnt + 1'b1;
            state <= ST_FMUL;
          end else if (cnt == 3'd1) begin
            det <= mac;
            if (mac == 52'sd0) begin
              // Degenerate texture mapping: skip the face entirely.
              deg   <= 1'b1;
              state <= ST_IDLE;
            end else begin
              cnt   <= cnt + 1'b1;
              state <= ST_FMUL;
            end
          end else begin
            num[2'(cnt[2:1] - 2'd1)] <= mac;
            if (cnt == 3'd7) begin
              cnt   <= '0;
              state <= ST_DLOAD;
            end else begin
              cnt   <= cnt + 1'b1;
              state <= ST_FMUL;
            end
          end
        end
        ST_DLOAD: begin
          rem   <= 52'(dvd[73:40]);
          dq    <= dvd[39:0];
          dvs   <= dvs_in;
          dsat  <= (52'(dvd[73:40]) >= dvs_in);
          dstep <= '0;
          state <= ST_DSTEP;
        end
        ST_DSTEP: begin
          rem   <= div_ge ? div_diff[51:0] : div_sh[51:0];
          dq    <= {dq[38:0], div_ge};
          dstep <= dstep + 1'b1;
          if (dstep == 6'd39) state <= ST_DEND;
        end
        ST_DEND: begin
          if (rd_mode) begin
            res[cnt[1:0]] <= mneg[cnt[1:0]] ? -(qv[23:0]) : qv[23:0];
          end else begin
            tq[cnt[1:0]] <= (num[cnt[1:0]][51] ^ det[51]) ? -48'(qv) : 48'(qv);
          end
          if (cnt == 3'd2) begin
            cnt   <= '0;
            state <= rd_mode ? ST_OUT : ST_RMW_RD;
          end else begin
            cnt   <= cnt + 1'b1;
            state <= ST_DLOAD;
          end
        end
        ST_RMW_RD: state <= ST_RMW_WR;
        ST_RMW_WR: begin
          if (cnt == 3'd2) begin
            state <= ST_IDLE;
          end else begin
            cnt   <= cnt + 1'b1;
            state <= ST_RMW_RD;
          end
        end
        ST_RRD: state <= ST_RCAP;
        ST_RCAP: begin
          tch   <= vi_ok && tch_rd;
          degen <= deg;
          deg   <= 1'b0;
          for (int k = 0; k < 3; k++) begin
            mag[k]  <= cap_m[k];
            mneg[k] <= sum_rd[k][47];
            res[k]  <= '0;
          end
          mx <= cap_max;
          if (cap_max == 48'd0) begin
            zero  <= 1'b1;
            state <= ST_OUT;
          end else begin
            zero  <= 1'b0;
            state <= ST_NORM;
          end
        end
        ST_NORM: begin
          // Bring the largest magnitude into [2^29, 2^30).
          if (mx[47:30] != '0) begin
            mx <= mx >> 1;
            for (int k = 0; k < 3; k++) mag[k] <= mag[k] >> 1;
          end else if (!mx[29]) begin
            mx <= mx << 1;
            for (int k = 0; k < 3; k++) mag[k] <= mag[k] << 1;
          end else begin
            cnt   <= '0;
            state <= ST_SQM;
          end
        end
        ST_SQM: state <= ST_SQA;
        ST_SQA: begin
          ss <= ss_sum;
          if (cnt == 3'd2) begin
            sx    <= ss_sum;
            sr    <= '0;
            sbit  <= 62'd1 << 60;
            state <= ST_ROOT;
          end else begin
            cnt   <= cnt + 1'b1;
            state <= ST_SQM;
          end
        end
        ST_ROOT: begin
          if (sbit == '0) begin
            len   <= sr[30:0];
            cnt   <= '0;
            state <= ST_DLOAD;
          end else begin
            if (sx >= root_try) begin
              sx <= sx - root_try;
              sr <= (sr >> 1) + sbit;
            end else begin
              sr <= sr >> 1;
            end
            sbit <= sbit >> 2;
          end
        end
        ST_OUT: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp.tangent_x       <= res[0];
            rsp.tangent_y       <= res[1];
            rsp.tangent_z       <= res[2];
            rsp.touched         <= tch;
            rsp.zero_length     <= zero;
            rsp.degenerate_seen <= degen;
            rsp_valid           <= 1'b1;
            state               <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/tsa_checker.sv
// Port-level checker of the tangent space accumulator, with its bind.
module tsa_checker (
  input logic          clk,
  input logic          rst,
  input logic          cmd_valid,
  input logic          cmd_stall,
  input tsa_pkg::cmd_t cmd,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input tsa_pkg::rsp_t rsp
);
  import tsa_pkg::*;

  // A stalled result beat holds its value.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result beat changed while stalled");

  // A zero-length result carries a zero tangent.
  a_zero_tangent: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.zero_length |->
      rsp.tangent_x == 24'sd0 && rsp.tangent_y == 24'sd0 && rsp.tangent_z == 24'sd0)
    else $error("zero-length result with a nonzero tangent");

  // A vertex that no face has touched has a zero sum.
  a_untouched_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.touched |-> rsp.zero_length)
    else $error("untouched vertex read with a nonzero tangent");

  // The clearing pass after reset keeps commands out.
  a_clear_stall: assert property (@(posedge clk)
    rst |=> cmd_stall)
    else $error("command port open right after reset");

endmodule

bind tangent_space_accumulator tsa_checker u_tsa_checker (.*);

// File: test/tsa_scoreboard.sv
// Scoreboard class holding the vertex-store tangent predictor and expected reads.
`timescale 1ns / 1ps
class tsa_scoreboard;
  localparam longint FACE_CAP = (64'sd1 <<< 40) - 1;
  localparam longint SUM_HI   = (64'sd1 <<< 47) - 1;
  localparam longint SUM_LO   = -(64'sd1 <<< 47);

  longint           vtx_pos[1024][3];
  longint           vtx_tex[1024][2];
  longint           vtx_sum[1024][3];
  bit               vtx_touched[1024];
  bit               skipped_face;
  tsa_pkg::rsp_t    pending_reads[$];
  int               fail_count;

  function new();
    for (int i = 0; i < 1024; i++) begin
      for (int k = 0; k < 3; k++) begin
        vtx_pos[i][k] = 0;
        vtx_sum[i][k] = 0;
      end
      vtx_tex[i][0] = 0;
      vtx_tex[i][1] = 0;
      vtx_touched[i] = 0;
    end
    skipped_face = 0;
    fail_count = 0;
  endfunction

  // Quotient num*2^22/det, truncated toward zero, magnitude capped at 2^40-1.
  function automatic longint face_ratio(longint num, longint det);
    bit [63:0] n, d, q, r;
    n = num < 0 ? -num : num;
    d = det < 0 ? -det : det;
    q = n / d;
    r = n % d;
    if (q >= (64'd1 << 18)) q = FACE_CAP;
    else begin
      for (int i = 0; i < 22; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= d) begin
          r = r - d;
          q[0] = 1'b1;
        end
      end
      if (q > FACE_CAP) q = FACE_CAP;
    end
    return ((num < 0) != (det < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic bit [63:0] int_sqrt(bit [63:0] x);
    bit [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else r = r >> 1;
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void add_face(int a, int b, int c);
    longint dv1, dv2, du1, du2, det, num;
    longint t[3];
    int corner[3];
    dv1 = vtx_tex[a][1] - vtx_tex[c][1];
    dv2 = vtx_tex[c][1] - vtx_tex[b][1];
    du1 = vtx_tex[c][0] - vtx_tex[a][0];
    du2 = vtx_tex[b][0] - vtx_tex[c][0];
    det = dv1 * du2 - dv2 * du1;
    if (det == 0) begin
      skipped_face = 1;
      return;
    end
    for (int k = 0; k < 3; k++) begin
      num = (vtx_pos[a][k] - vtx_pos[c][k]) * dv2 + (vtx_pos[b][k] - vtx_pos[c][k]) * dv1;
      t[k] = face_ratio(num, det);
    end
    corner[0] = a;
    corner[1] = b;
    corner[2] = c;
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        vtx_sum[corner[j]][k] = vtx_sum[corner[j]][k] + t[k];
        if (vtx_sum[corner[j]][k] > SUM_HI) vtx_sum[corner[j]][k] = SUM_HI;
        if (vtx_sum[corner[j]][k] < SUM_LO) vtx_sum[corner[j]][k] = SUM_LO;
      end
      vtx_touched[corner[j]] = 1;
    end
  endfunction

  function automatic tsa_pkg::rsp_t normalized_read(int vi);
    tsa_pkg::rsp_t res;
    bit [63:0] m[3];
    bit [63:0] mx, ss, len, q;
    res = '0;
    res.zero_length = 1;
    if (vi < tsa_pkg::MAX_VERTICES) begin
      res.touched = vtx_touched[vi];
      mx = 0;
      for (int k = 0; k < 3; k++) begin
        m[k] = vtx_sum[vi][k] < 0 ? -vtx_sum[vi][k] : vtx_sum[vi][k];
        if (m[k] > mx) mx = m[k];
      end
      if (mx != 0) begin
        res.zero_length = 0;
        while (mx >= (64'd1 << 30)) begin
          mx = mx >> 1;
          for (int k = 0; k < 3; k++) m[k] = m[k] >> 1;
        end
        while (mx < (64'd1 << 29)) begin
          mx = mx << 1;
          for (int k = 0; k < 3; k++) m[k] = m[k] << 1;
        end
        ss = 0;
        for (int k = 0; k < 3; k++) ss = ss + m[k] * m[k];
        len = int_sqrt(ss);
        for (int k = 0; k < 3; k++) begin
          q = ((m[k] << 22) + (len >> 1)) / len;
          if (vtx_sum[vi][k] < 0) q = -q;
          if (k == 0) res.tangent_x = q[23:0];
          if (k == 1) res.tangent_y = q[23:0];
          if (k == 2) res.tangent_z = q[23:0];
        end
      end
    end
    res.degenerate_seen = skipped_face;
    skipped_face = 0;
    return res;
  endfunction

  // Applies one accepted command beat to the predicted vertex store.
  function void note_command(tsa_pkg::cmd_t c);
    int vi;
    vi = c.vertex_index;
    case (c.action)
      tsa_pkg::ACT_LOAD: begin
        if (vi < tsa_pkg::MAX_VERTICES) begin
          vtx_pos[vi][0] = c.pos_x;
          vtx_pos[vi][1] = c.pos_y;
          vtx_pos[vi][2] = c.pos_z;
          vtx_tex[vi][0] = c.tex_u;
          vtx_tex[vi][1] = c.tex_v;
          for (int k = 0; k < 3; k++) vtx_sum[vi][k] = 0;
          vtx_touched[vi] = 0;
        end
      end
      tsa_pkg::ACT_FACE: begin
        if (c.corner_a < tsa_pkg::MAX_VERTICES && c.corner_b < tsa_pkg::MAX_VERTICES &&
            c.corner_c < tsa_pkg::MAX_VERTICES)
          add_face(c.corner_a, c.corner_b, c.corner_c);
      end
      tsa_pkg::ACT_READ: pending_reads.push_back(normalized_read(vi));
      default: ;
    endcase
  endfunction

  function void check_result(tsa_pkg::rsp_t got);
    tsa_pkg::rsp_t exp;
    if (pending_reads.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      fail_count++;
      return;
    end
    exp = pending_reads.pop_front();
    if (got.tangent_x !== exp.tangent_x) begin
      $display("%0t: tangent_x exp %0d got %0d", $time, exp.tangent_x, got.tangent_x);
      fail_count++;
    end
    if (got.tangent_y !== exp.tangent_y) begin
      $display("%0t: tangent_y exp %0d got %0d", $time, exp.tangent_y, got.tangent_y);
      fail_count++;
    end
    if (got.tangent_z !== exp.tangent_z) begin
      $display("%0t: tangent_z exp %0d got %0d", $time, exp.tangent_z, got.tangent_z);
      fail_count++;
    end
    if (got.touched !== exp.touched) begin
      $display("%0t: touched exp %0b got %0b", $time, exp.touched, got.touched);
      fail_count++;
    end
    if (got.zero_length !== exp.zero_length) begin
      $display("%0t: zero_length exp %0b got %0b", $time, exp.zero_length, got.zero_length);
      fail_count++;
    end
    if (got.degenerate_seen !== exp.degenerate_seen) begin
      $display("%0t: degenerate_seen exp %0b got %0b", $time, exp.degenerate_seen,
               got.degenerate_seen);
      fail_count++;
    end
  endfunction
endclass

// File: test/tb_top.sv
// Top-level testbench of the tangent space accumulator.
`timescale 1ns / 1ps
module tb_top;
  import tsa_pkg::*;

  localparam int POOL = 16;            // vertices used by most random meshes
  localparam longint CYCLE_LIMIT = 3000000;

  logic clk;
  logic rst;
  logic cmd_valid;
  logic cmd_stall;
  cmd_t cmd;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  tsa_scoreboard board;
  bit     loaded[1024];
  bit     quiet_mode;      // no idling on either side while set
  bit     hold_off;        // receiver keeps stalling for a long stretch
  longint cycle_count;

  tangent_space_accumulator DUT (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic bit want_idle();
    return !quiet_mode && ($urandom_range(99) < 32);
  endfunction

  // Random filler for the fields a command does not use.
  function automatic cmd_t noise_cmd();
    logic [191:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return bits[$bits(cmd_t)-1:0];
  endfunction

  // Offers one command beat and holds it until the block takes it. The
  // predictor sees the beat at the edge where it is accepted.
  task automatic send_beat(cmd_t c);
    while (want_idle()) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    board.note_command(c);
  endtask

  // The next command is idled at the top of send_beat, so valid is otherwise
  // lowered only once the stimulus is finished.
  task automatic load_vertex(int vi, logic signed [23:0] px, py, pz, tu, tv);
    cmd_t c;
    c = noise_cmd();
    c.action = ACT_LOAD;
    c.vertex_index = 10'(vi);
    c.pos_x = px;
    c.pos_y = py;
    c.pos_z = pz;
    c.tex_u = tu;
    c.tex_v = tv;
    send_beat(c);
    if (vi < MAX_VERTICES) loaded[vi] = 1;
  endtask

  task automatic face(int a, int b, int c3);
    cmd_t c;
    c = noise_cmd();
    c.action = ACT_FACE;
    c.corner_a = 10'(a);
    c.corner_b = 10'(b);
    c.corner_c = 10'(c3);
    send_beat(c);
  endtask

  task automatic read_vertex(int vi);
    cmd_t c;
    c = noise_cmd();
    c.action = ACT_READ;
    c.vertex_index = 10'(vi);
    send_beat(c);
  endtask

  function automatic logic signed [23:0] rand_q(int spread);
    // Mostly modest coordinates, sometimes full range so every bit toggles.
    if ($urandom_range(7) == 0) return 24'($urandom);
    return 24'($signed($urandom_range(2 * spread)) - spread);
  endfunction

  function automatic int loaded_index();
    int vi;
    do vi = $urandom_range(POOL - 1); while (!loaded[vi]);
    return vi;
  endfunction

  // Result side: random stall, plus a long hold-off on request.
  always @(posedge clk) begin
    if (rst) rsp_stall <= 1'b0;
    else rsp_stall <= hold_off || want_idle();
    if (!rst && rsp_valid && !rsp_stall) board.check_result(rsp);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver hold-off counted in its own process while reads keep coming.
  task automatic long_hold();
    hold_off = 1;
    repeat (3000) @(posedge clk);
    hold_off = 0;
  endtask

  initial begin
    cycle_count = 0;
    rst = 1'b1;
    cmd_valid = 1'b0;
    cmd = '0;
    rsp_stall = 1'b0;
    hold_off = 0;
    quiet_mode = 0;
    board = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, both signs of the tangent, a skipped face,
    // repeated corners, reloads and an unknown action.
    load_vertex(0, 24'sh7FFFFF, 24'sh800000, '0, '0, '0);
    load_vertex(1, 24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000);
    load_vertex(2, 24'sh010000, '0, 24'sh800000, 24'sh800000, 24'sh7FFFFF);
    load_vertex(3, '0, '0, '0, '0, '0);
    load_vertex(1023, 24'sh123456, 24'shFEDCBA, 24'sh000001, 24'sh010000, 24'sh020000);
    load_vertex(1022, '0, 24'sh010000, '0, 24'sh010000, '0);
    read_vertex(0);                      // untouched vertex
    face(0, 1, 2);
    face(0, 0, 3);                       // zero determinant: skipped
    read_vertex(0);
    read_vertex(1);
    face(1023, 1022, 0);
    face(2, 2, 1);                       // repeated corner, degenerate
    face(1, 2, 1023);
    read_vertex(1023);
    read_vertex(2);
    read_vertex(3);
    face(0, 1, 3);
    load_vertex(3, 24'sd1, 24'sd1, 24'sd1, 24'sd1, 24'sd1); // reload clears sum and touched
    read_vertex(3);
    send_beat('{action: 2'd3, default: '1});
    read_vertex(1022);

    // Random meshes over a small vertex pool, with some noise.
    for (int n = 0; n < 2000; n++) begin
      int pick;
      if (n == 600) quiet_mode = 1;
      if (n == 800) quiet_mode = 0;
      if (n == 1000) fork long_hold(); join_none
      pick = $urandom_range(99);
      if (n < 8 || pick < 25)
        load_vertex($urandom_range(POOL - 1), rand_q(400000), rand_q(400000),
                    rand_q(400000), rand_q(200000), rand_q(200000));
      else if (pick < 65)
        face(loaded_index(), loaded_index(), loaded_index());
      else if (pick < 95)
        read_vertex($urandom_range(9) == 0 ? $urandom_range(1023) : loaded_index());
      else if (pick < 98)
        face(loaded_index(), loaded_index(), 0);
      else
        send_beat('{action: 2'd3, default: '0});
    end
    cmd_valid <= 1'b0;

    while (board.pending_reads.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (board.fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
